// ----- sv/tes_pkg.sv -----
// Shared types, codes and constants for the track element sequencer.
package tes_pkg;

   localparam int DistFracBitsDefault = 4;
   localparam int DistWidthDefault    = 16;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 14;

   localparam logic [CsrIndexWidth-1:0] CSR_SPEED_CURVE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SPEED_STOP  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SPEED_FAST  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RING_ENABLE = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_DRIVE_DUTY  = 3'd4;

   localparam logic [7:0]  SPEED_CURVE_RESET = 8'd50;
   localparam logic [7:0]  SPEED_STOP_RESET  = 8'd0;
   localparam logic [7:0]  SPEED_FAST_RESET  = 8'd80;
   localparam logic [13:0] DRIVE_DUTY_RESET  = 14'd6000;

   localparam logic [1:0] MODE_NORMAL  = 2'd0;
   localparam logic [1:0] MODE_ELEMENT = 2'd1;
   localparam logic [1:0] MODE_LOST    = 2'd2;

   localparam logic [2:0] RING_IDLE   = 3'd0;
   localparam logic [2:0] RING_ENTRY  = 3'd1;
   localparam logic [2:0] RING_INSIDE = 3'd2;
   localparam logic [2:0] RING_FAST   = 3'd3;
   localparam logic [2:0] RING_EXIT   = 3'd4;
   localparam logic [2:0] RING_DONE   = 3'd5;

   localparam logic [2:0] LOST_IDLE    = 3'd0;
   localparam logic [2:0] LOST_CONFIRM = 3'd1;
   localparam logic [2:0] LOST_TURN    = 3'd2;
   localparam logic [2:0] LOST_DRIVE   = 3'd3;
   localparam logic [2:0] LOST_RECOVER = 3'd4;

   localparam logic [1:0] CROSS_IDLE = 2'd0;
   localparam logic [1:0] CROSS_PASS = 2'd1;
   localparam logic [1:0] CROSS_HOLD = 2'd2;

   localparam logic signed [7:0] OFS_ZERO   = 8'sd0;
   localparam logic signed [7:0] OFS_NEG15  = -8'sd15;
   localparam logic signed [7:0] OFS_NEG100 = -8'sd100;

   // Distance thresholds in whole centimeters; 10.5 cm is kept in half centimeters.
   localparam int CmRingCheckHalf = 21;
   localparam int CmRingInside    = 30;
   localparam int CmRingFast      = 380;
   localparam int CmRingExit      = 50;
   localparam int CmLostConfirm   = 19;
   localparam int CmLostTurn      = 25;
   localparam int CmLostDrive     = 50;
   localparam int CmLostRecover   = 10;
   localparam int CmStopHold      = 30;
   localparam int CmCrossPass     = 15;
   localparam int CmCrossHold     = 20;

   typedef struct packed {
      logic        left_outer;
      logic        left_inner;
      logic        center_eye;
      logic        right_inner;
      logic        right_outer;
      logic [7:0]  distance_step;
   } req_type;

   typedef struct packed {
      logic [7:0]        speed_out;
      logic              steer_enable;
      logic signed [7:0] steer_offset;
      logic              speed_loop_on;
      logic              drive_load;
      logic [1:0]        mode_out;
      logic [2:0]        ring_out;
      logic [2:0]        lost_out;
      logic [1:0]        cross_out;
      logic              stop_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  speed_curve;
      logic [7:0]  speed_stop;
      logic [7:0]  speed_fast;
      logic        ring_enable;
      logic [13:0] drive_duty;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        element_mode;
      logic [2:0]        ring_phase;
      logic [2:0]        lost_phase;
      logic [1:0]        cross_phase;
      logic              stop_latched;
      logic [7:0]        speed_reg;
      logic              steer_en_reg;
      logic              pwm_en_reg;
      logic signed [7:0] offset_reg;
   } seq_state_type;

endpackage

// ----- sv/track_element_sequencer_top.sv -----
// Top level of the track element sequencer: input register, step logic, result register.
//
//  Channel   Ports                          Direction  Contents
//  request   req_valid, req_stall, req_data  in         five sensor bits and distance step
//  response  rsp_valid, rsp_stall, rsp_data  out        drive settings and sequence phases
//  config    csr_we, csr_index, csr_wdata    in         speed, ring enable and duty registers
//
// An accepted request waits in the input register; the sequencer state updates as its result
// loads the result register. One request is taken per clock unless the request side stalls.
// Synchronous reset clears both register stages and returns all sequences to their idle phase.
// A stall on the response side holds the result; once the input register is also full,
// the request side stalls in the same cycle.
module track_element_sequencer_top #(
   parameter int DIST_FRAC_BITS = tes_pkg::DistFracBitsDefault,
   parameter int DIST_WIDTH     = tes_pkg::DistWidthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tes_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tes_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [tes_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [tes_pkg::CsrDataWidth-1:0]   csr_wdata
);

   tes_pkg::cfg_type       cfg;
   logic                   s1_valid_ff, s1_valid_in;
   tes_pkg::req_type       s1_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   tes_pkg::rsp_type       rsp_data_ff, step_rsp;
   tes_pkg::seq_state_type state_ff, state_in;
   logic [DIST_WIDTH-1:0]  travelled_ff, travelled_in;
   logic                   out_ready, s1_fire, req_accept;

   tes_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tes_step #(
      .DIST_FRAC_BITS (DIST_FRAC_BITS),
      .DIST_WIDTH     (DIST_WIDTH)
   ) u_step (
      .cfg          (cfg),
      .req          (s1_data_ff),
      .state        (state_ff),
      .travelled    (travelled_ff),
      .state_in     (state_in),
      .travelled_in (travelled_in),
      .rsp          (step_rsp)
   );

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire      = s1_valid_ff && out_ready;
   assign req_stall    = s1_valid_ff && !out_ready;
   assign req_accept   = req_valid && !req_stall;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         travelled_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            state_ff     <= state_in;
            travelled_ff <= travelled_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The sequencer state only moves when a transaction leaves the input register.
   assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> ($stable(travelled_ff) && $stable(state_ff)))
      else $error("sequencer state changed without a transaction");

   // A held input transaction reaches the result register as soon as it has room.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_ready |=> rsp_valid_ff)
      else $error("input transaction did not advance to the result register");

   // Once the finish zone is detected it stays detected.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.stop_latched |=> state_ff.stop_latched)
      else $error("finish zone latch cleared");

   // A fixed-duty load always hands the motors over from the speed loop.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.drive_load |-> !rsp_data_ff.speed_loop_on)
      else $error("fixed duty loaded while the speed loop is active");

endmodule

// ----- sv/tes_csr.sv -----
// Configuration register file of the track element sequencer.
module tes_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [tes_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [tes_pkg::CsrDataWidth-1:0]      csr_wdata,
   output tes_pkg::cfg_type                      cfg
);

   tes_pkg::cfg_type cfg_ff;
   tes_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tes_pkg::CSR_SPEED_CURVE: cfg_in.speed_curve = csr_wdata[7:0];
            tes_pkg::CSR_SPEED_STOP:  cfg_in.speed_stop  = csr_wdata[7:0];
            tes_pkg::CSR_SPEED_FAST:  cfg_in.speed_fast  = csr_wdata[7:0];
            tes_pkg::CSR_RING_ENABLE: cfg_in.ring_enable = csr_wdata[0];
            tes_pkg::CSR_DRIVE_DUTY:  cfg_in.drive_duty  = csr_wdata[13:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_curve <= tes_pkg::SPEED_CURVE_RESET;
         cfg_ff.speed_stop  <= tes_pkg::SPEED_STOP_RESET;
         cfg_ff.speed_fast  <= tes_pkg::SPEED_FAST_RESET;
         cfg_ff.ring_enable <= 1'b0;
         cfg_ff.drive_duty  <= tes_pkg::DRIVE_DUTY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/tes_step.sv -----
// Per-tick sequencing logic: distance accumulation and all element sub-sequences.
module tes_step #(
   parameter int DIST_FRAC_BITS = tes_pkg::DistFracBitsDefault,
   parameter int DIST_WIDTH     = tes_pkg::DistWidthDefault
) (
   input  tes_pkg::cfg_type        cfg,
   input  tes_pkg::req_type        req,
   input  tes_pkg::seq_state_type  state,
   input  logic [DIST_WIDTH-1:0]   travelled,
   output tes_pkg::seq_state_type  state_in,
   output logic [DIST_WIDTH-1:0]   travelled_in,
   output tes_pkg::rsp_type        rsp
);

   // Compare width covers both the counter and the largest threshold.
   localparam int CmpWidth = (DIST_WIDTH > 9 + DIST_FRAC_BITS) ? DIST_WIDTH
                                                               : 9 + DIST_FRAC_BITS;

   localparam logic [CmpWidth-1:0] ThRingCheck =
      CmpWidth'(tes_pkg::CmRingCheckHalf) << (DIST_FRAC_BITS - 1);
   localparam logic [CmpWidth-1:0] ThRingInside  = CmpWidth'(tes_pkg::CmRingInside)  << DIST_FRAC_BITS;
   localparam logic [CmpWidth-1:0] ThRingFast    = CmpWidth'(tes_pkg::CmRingFast)    << DIST_FRAC_BITS;
   localparam logic [CmpWidth-1:0] ThRingExit    = CmpWidth'(tes_pkg::CmRingExit)    << DIST_FRAC_BITS;
   localparam logic [CmpWidth-1:0] ThLostConfirm = CmpWidth'(tes_pkg::CmLostConfirm) << DIST_FRAC_BITS;
   localparam logic [CmpWidth-1:0] ThLostTurn    = CmpWidth'(tes_pkg::CmLostTurn)    << DIST_FRAC_BITS;
   localparam logic [CmpWidth-1:0] ThLostDrive   = CmpWidth'(tes_pkg::CmLostDrive)   << DIST_FRAC_BITS;
   localparam logic [CmpWidth-1:0] ThLostRecover = CmpWidth'(tes_pkg::CmLostRecover) << DIST_FRAC_BITS;
   localparam logic [CmpWidth-1:0] ThStopHold    = CmpWidth'(tes_pkg::CmStopHold)    << DIST_FRAC_BITS;
   localparam logic [CmpWidth-1:0] ThCrossPass   = CmpWidth'(tes_pkg::CmCrossPass)   << DIST_FRAC_BITS;
   localparam logic [CmpWidth-1:0] ThCrossHold   = CmpWidth'(tes_pkg::CmCrossHold)   << DIST_FRAC_BITS;

   logic               l2, l1, m, r1, r2;
   logic               all_white, all_black;
   logic [DIST_WIDTH:0] dist_sum;
   logic [DIST_WIDTH-1:0] dist_sat;

   assign l2 = req.left_outer;
   assign l1 = req.left_inner;
   assign m  = req.center_eye;
   assign r1 = req.right_inner;
   assign r2 = req.right_outer;
   assign all_white = l2 & l1 & m & r1 & r2;
   assign all_black = ~(l2 | l1 | m | r1 | r2);

   assign dist_sum = {1'b0, travelled} + (DIST_WIDTH + 1)'(req.distance_step);
   assign dist_sat = dist_sum[DIST_WIDTH] ? {DIST_WIDTH{1'b1}} : dist_sum[DIST_WIDTH-1:0];

   always_comb begin
      tes_pkg::seq_state_type s;
      logic [CmpWidth-1:0]    t;
      logic                   load;
      s    = state;
      t    = CmpWidth'(dist_sat);
      load = 1'b0;

      if (s.element_mode == tes_pkg::MODE_NORMAL) begin
         s.steer_en_reg = 1'b1;
         s.pwm_en_reg   = 1'b1;
         s.speed_reg    = cfg.speed_curve;
      end

      if (cfg.ring_enable) begin
         if (s.element_mode == tes_pkg::MODE_NORMAL && s.ring_phase == tes_pkg::RING_IDLE &&
             s.lost_phase == tes_pkg::LOST_RECOVER && s.cross_phase == tes_pkg::CROSS_PASS) begin
            if (r2 && m && (!l1 || !r1) && !l2) begin
               s.ring_phase = tes_pkg::RING_ENTRY;
               t = '0;
            end
         end
         if (s.ring_phase == tes_pkg::RING_ENTRY && t >= ThRingCheck) begin
            if ((!l1 && m && !r1) || ((l1 || r1) && m)) begin
               s.ring_phase   = tes_pkg::RING_INSIDE;
               t              = '0;
               s.element_mode = tes_pkg::MODE_ELEMENT;
               s.steer_en_reg = 1'b0;
               s.offset_reg   = tes_pkg::OFS_NEG15;
            end else begin
               s.ring_phase = tes_pkg::RING_IDLE;
            end
         end
         if (s.ring_phase == tes_pkg::RING_INSIDE && t > ThRingInside) begin
            s.steer_en_reg = 1'b1;
            s.ring_phase   = tes_pkg::RING_FAST;
            s.speed_reg    = cfg.speed_fast;
         end
         if (s.ring_phase == tes_pkg::RING_FAST && t > ThRingFast) begin
            if (l2 && m && !r2) begin
               t              = '0;
               s.steer_en_reg = 1'b0;
               s.offset_reg   = tes_pkg::OFS_NEG15;
               s.ring_phase   = tes_pkg::RING_EXIT;
            end
         end
         if (s.ring_phase == tes_pkg::RING_EXIT && t > ThRingExit) begin
            s.element_mode = tes_pkg::MODE_NORMAL;
            s.ring_phase   = tes_pkg::RING_DONE;
            t              = '0;
         end
      end

      if (s.element_mode == tes_pkg::MODE_NORMAL && s.lost_phase == tes_pkg::LOST_IDLE &&
          all_white) begin
         s.lost_phase = tes_pkg::LOST_CONFIRM;
         t = '0;
      end
      if (s.lost_phase == tes_pkg::LOST_CONFIRM) begin
         if (all_white) begin
            if (t > ThLostConfirm) begin
               s.element_mode = tes_pkg::MODE_LOST;
               s.steer_en_reg = 1'b0;
               s.offset_reg   = tes_pkg::OFS_NEG100;
               s.lost_phase   = tes_pkg::LOST_TURN;
               t              = '0;
            end
         end else begin
            t            = '0;
            s.lost_phase = tes_pkg::LOST_IDLE;
         end
      end
      if (s.lost_phase == tes_pkg::LOST_TURN && t > ThLostTurn) begin
         s.lost_phase = tes_pkg::LOST_DRIVE;
         s.pwm_en_reg = 1'b0;
         load         = 1'b1;
      end
      if (s.lost_phase == tes_pkg::LOST_DRIVE && t >= ThLostDrive && !all_white) begin
         s.lost_phase   = tes_pkg::LOST_RECOVER;
         s.element_mode = tes_pkg::MODE_NORMAL;
         t              = '0;
      end
      if (s.lost_phase == tes_pkg::LOST_RECOVER && t > ThLostRecover) begin
         s.lost_phase = tes_pkg::LOST_IDLE;
      end

      if (s.element_mode == tes_pkg::MODE_NORMAL && !s.stop_latched &&
          s.ring_phase == tes_pkg::RING_DONE && all_white) begin
         s.stop_latched = 1'b1;
         t = '0;
      end
      if (s.stop_latched && t >= ThStopHold) begin
         s.steer_en_reg = 1'b0;
         s.speed_reg    = cfg.speed_stop;
      end

      if (s.element_mode == tes_pkg::MODE_NORMAL && s.ring_phase == tes_pkg::RING_IDLE &&
          s.cross_phase == tes_pkg::CROSS_IDLE && all_black) begin
         s.cross_phase  = tes_pkg::CROSS_PASS;
         s.element_mode = tes_pkg::MODE_ELEMENT;
         s.steer_en_reg = 1'b0;
         s.offset_reg   = tes_pkg::OFS_ZERO;
         t              = '0;
      end
      if (s.cross_phase == tes_pkg::CROSS_PASS && t > ThCrossPass) begin
         s.cross_phase  = tes_pkg::CROSS_HOLD;
         s.element_mode = tes_pkg::MODE_NORMAL;
         s.steer_en_reg = 1'b1;
         t              = '0;
      end
      if (s.cross_phase == tes_pkg::CROSS_HOLD && t > ThCrossHold) begin
         s.cross_phase = tes_pkg::CROSS_IDLE;
      end

      state_in     = s;
      travelled_in = t[DIST_WIDTH-1:0];

      rsp.speed_out     = s.speed_reg;
      rsp.steer_enable  = s.steer_en_reg;
      rsp.steer_offset  = s.offset_reg;
      rsp.speed_loop_on = s.pwm_en_reg;
      rsp.drive_load    = load;
      rsp.mode_out      = s.element_mode;
      rsp.ring_out      = s.ring_phase;
      rsp.lost_out      = s.lost_phase;
      rsp.cross_out     = s.cross_phase;
      rsp.stop_out      = s.stop_latched;
   end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the track element sequencer: directed table, then random scenes.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tes_pkg::*;

   localparam int FracBits  = DistFracBitsDefault;
   localparam int DistWidth = DistWidthDefault;

   // Distance thresholds in counter units.
   localparam int RingCheckDist   = CmRingCheckHalf << (FracBits - 1);
   localparam int RingInsideDist  = CmRingInside << FracBits;
   localparam int RingFastDist    = CmRingFast << FracBits;
   localparam int RingExitDist    = CmRingExit << FracBits;
   localparam int LostConfirmDist = CmLostConfirm << FracBits;
   localparam int LostTurnDist    = CmLostTurn << FracBits;
   localparam int LostDriveDist   = CmLostDrive << FracBits;
   localparam int LostRecoverDist = CmLostRecover << FracBits;
   localparam int StopHoldDist    = CmStopHold << FracBits;
   localparam int CrossPassDist   = CmCrossPass << FracBits;
   localparam int CrossHoldDist   = CmCrossHold << FracBits;

   localparam logic [CsrIndexWidth-1:0] CSR_PAST_END = CSR_DRIVE_DUTY + 3'd1;

   localparam int TimeoutNs     = 1_000_000;
   localparam int MaxPrinted    = 50;
   localparam int PhaseCount    = 8;
   localparam int PhaseItems    = 180;
   localparam int CruiseItems   = 280;
   localparam int SendIdlePct [4] = '{0, 59, 0, 18};
   localparam int StallPct    [4] = '{0, 0, 59, 18};

   localparam rsp_type CruiseAtReset = rsp_type'({SPEED_CURVE_RESET, 1'b1, OFS_ZERO, 1'b1,
      1'b0, MODE_NORMAL, RING_IDLE, LOST_IDLE, CROSS_IDLE, 1'b0});
   localparam rsp_type CrossAtReset = rsp_type'({SPEED_CURVE_RESET, 1'b0, OFS_ZERO, 1'b1,
      1'b0, MODE_ELEMENT, RING_IDLE, LOST_IDLE, CROSS_PASS, 1'b0});

   typedef enum int {
      SCENE_WHITE,
      SCENE_BLACK,
      SCENE_RING,
      SCENE_NOISE
   } scene_kind_type;

   typedef struct {
      logic [4:0] eyes;
      logic [7:0] step;
      bit         typed;
      rsp_type    want;
   } dir_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int mismatch_count = 0;

   rsp_type expected_q[$];
   rsp_type want_rsp;

   // Shadow of the registers and the sequencer state.
   cfg_type               reg_shadow;
   logic [DistWidth-1:0]  trip_dist;
   logic [1:0]            elem_mode;
   logic [2:0]            ring_ph;
   logic [2:0]            lost_ph;
   logic [1:0]            cross_ph;
   logic                  stop_seen;
   logic [7:0]            speed_val;
   logic                  steer_on;
   logic                  pwm_on;
   logic signed [7:0]     offset_val;

   // Eyes are left_outer, left_inner, center_eye, right_inner, right_outer; 1 is white.
   dir_row_type dir_rows [17] = '{
      '{5'b11011, 8'd0,   1'b1, CruiseAtReset},
      '{5'b10101, 8'd255, 1'b1, CruiseAtReset},
      '{5'b00000, 8'd0,   1'b1, CrossAtReset},
      '{5'b01110, 8'd255, 1'b0, '0},
      '{5'b11011, 8'd255, 1'b0, '0},
      '{5'b11011, 8'd100, 1'b0, '0},
      '{5'b11111, 8'd10,  1'b0, '0},
      '{5'b11111, 8'd255, 1'b0, '0},
      '{5'b11111, 8'd100, 1'b0, '0},
      '{5'b00000, 8'd255, 1'b0, '0},
      '{5'b01010, 8'd200, 1'b0, '0},
      '{5'b11111, 8'd255, 1'b0, '0},
      '{5'b11111, 8'd255, 1'b0, '0},
      '{5'b00000, 8'd0,   1'b0, '0},
      '{5'b11011, 8'd161, 1'b0, '0},
      '{5'b11011, 8'd80,  1'b0, '0},
      '{5'b11111, 8'd0,   1'b0, '0}
   };

   track_element_sequencer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #(TimeoutNs);
      $display("tb: failure");
      $finish;
   end

   // Advances the sequencer shadow by one tick and returns the drive settings it produces.
   function automatic rsp_type advance_sequencer(req_type item);
      logic l2, l1, m, r1, r2;
      logic all_white, all_black, load;
      logic [DistWidth:0] sum;
      rsp_type r;
      l2 = item.left_outer;
      l1 = item.left_inner;
      m  = item.center_eye;
      r1 = item.right_inner;
      r2 = item.right_outer;
      all_white = l2 & l1 & m & r1 & r2;
      all_black = ~(l2 | l1 | m | r1 | r2);
      load = 1'b0;

      sum = {1'b0, trip_dist} + (DistWidth + 1)'(item.distance_step);
      trip_dist = sum[DistWidth] ? '1 : sum[DistWidth-1:0];

      if (elem_mode == MODE_NORMAL) begin
         steer_on  = 1'b1;
         pwm_on    = 1'b1;
         speed_val = reg_shadow.speed_curve;
      end

      if (reg_shadow.ring_enable) begin
         if (elem_mode == MODE_NORMAL && ring_ph == RING_IDLE && lost_ph == LOST_RECOVER &&
               cross_ph == CROSS_PASS && r2 && m && (!l1 || !r1) && !l2) begin
            ring_ph   = RING_ENTRY;
            trip_dist = '0;
         end
         if (ring_ph == RING_ENTRY && trip_dist >= RingCheckDist) begin
            if ((!l1 && m && !r1) || ((l1 || r1) && m)) begin
               ring_ph    = RING_INSIDE;
               trip_dist  = '0;
               elem_mode  = MODE_ELEMENT;
               steer_on   = 1'b0;
               offset_val = OFS_NEG15;
            end else begin
               ring_ph = RING_IDLE;
            end
         end
         if (ring_ph == RING_INSIDE && trip_dist > RingInsideDist) begin
            steer_on  = 1'b1;
            ring_ph   = RING_FAST;
            speed_val = reg_shadow.speed_fast;
         end
         if (ring_ph == RING_FAST && trip_dist > RingFastDist && l2 && m && !r2) begin
            trip_dist  = '0;
            steer_on   = 1'b0;
            offset_val = OFS_NEG15;
            ring_ph    = RING_EXIT;
         end
         if (ring_ph == RING_EXIT && trip_dist > RingExitDist) begin
            elem_mode = MODE_NORMAL;
            ring_ph   = RING_DONE;
            trip_dist = '0;
         end
      end

      if (elem_mode == MODE_NORMAL && lost_ph == LOST_IDLE && all_white) begin
         lost_ph   = LOST_CONFIRM;
         trip_dist = '0;
      end
      if (lost_ph == LOST_CONFIRM) begin
         if (!all_white) begin
            trip_dist = '0;
            lost_ph   = LOST_IDLE;
         end else if (trip_dist > LostConfirmDist) begin
            elem_mode  = MODE_LOST;
            steer_on   = 1'b0;
            offset_val = OFS_NEG100;
            lost_ph    = LOST_TURN;
            trip_dist  = '0;
         end
      end
      if (lost_ph == LOST_TURN && trip_dist > LostTurnDist) begin
         lost_ph = LOST_DRIVE;
         pwm_on  = 1'b0;
         load    = 1'b1;
      end
      if (lost_ph == LOST_DRIVE && trip_dist >= LostDriveDist && !all_white) begin
         lost_ph   = LOST_RECOVER;
         elem_mode = MODE_NORMAL;
         trip_dist = '0;
      end
      if (lost_ph == LOST_RECOVER && trip_dist > LostRecoverDist)
         lost_ph = LOST_IDLE;

      if (elem_mode == MODE_NORMAL && !stop_seen && ring_ph == RING_DONE && all_white) begin
         stop_seen = 1'b1;
         trip_dist = '0;
      end
      if (stop_seen && trip_dist >= StopHoldDist) begin
         steer_on  = 1'b0;
         speed_val = reg_shadow.speed_stop;
      end

      if (elem_mode == MODE_NORMAL && ring_ph == RING_IDLE && cross_ph == CROSS_IDLE &&
            all_black) begin
         cross_ph   = CROSS_PASS;
         elem_mode  = MODE_ELEMENT;
         steer_on   = 1'b0;
         offset_val = OFS_ZERO;
         trip_dist  = '0;
      end
      if (cross_ph == CROSS_PASS && trip_dist > CrossPassDist) begin
         cross_ph  = CROSS_HOLD;
         elem_mode = MODE_NORMAL;
         steer_on  = 1'b1;
         trip_dist = '0;
      end
      if (cross_ph == CROSS_HOLD && trip_dist > CrossHoldDist)
         cross_ph = CROSS_IDLE;

      r.speed_out     = speed_val;
      r.steer_enable  = steer_on;
      r.steer_offset  = offset_val;
      r.speed_loop_on = pwm_on;
      r.drive_load    = load;
      r.mode_out      = elem_mode;
      r.ring_out      = ring_ph;
      r.lost_out      = lost_ph;
      r.cross_out     = cross_ph;
      r.stop_out      = stop_seen;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < MaxPrinted)
         $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Leaves csr_we high; the caller lowers it after the last write of a batch.
   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SPEED_CURVE: reg_shadow.speed_curve = value[7:0];
         CSR_SPEED_STOP:  reg_shadow.speed_stop  = value[7:0];
         CSR_SPEED_FAST:  reg_shadow.speed_fast  = value[7:0];
         CSR_RING_ENABLE: reg_shadow.ring_enable = value[0];
         CSR_DRIVE_DUTY:  reg_shadow.drive_duty  = value;
         default: ;
      endcase
   endtask

   // Offers one transaction and, once it is taken, queues the drive settings it should yield.
   task automatic send_item(req_type item, bit typed, rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = advance_sequencer(item);
      expected_q.push_back(typed ? typed_rsp : predicted);
   endtask

   // Runs of sensor patterns: long white stretches walk the lost-line sequence, black
   // bursts open crossroads, and ring-shaped patterns probe the ring entry and exit.
   task automatic drive_track(int count);
      int             sent;
      int             len;
      int             pick;
      scene_kind_type kind;
      req_type        item;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 9);
         kind = (pick < 3) ? SCENE_WHITE : (pick < 5) ? SCENE_BLACK :
                (pick < 6) ? SCENE_RING : SCENE_NOISE;
         case (kind)
            SCENE_WHITE: len = $urandom_range(2, 16);
            SCENE_BLACK: len = $urandom_range(1, 3);
            SCENE_RING:  len = $urandom_range(1, 6);
            default:     len = $urandom_range(1, 20);
         endcase
         for (int k = 0; k < len; k++) begin
            item = req_type'(13'($urandom));
            case (kind)
               SCENE_WHITE: begin
                  item = req_type'({5'b11111, 8'd0});
                  item.distance_step = 8'($urandom_range(0, 80));
               end
               SCENE_BLACK: item[12:8] = '0;
               SCENE_RING: begin
                  item.center_eye = 1'b1;
                  if ($urandom_range(0, 1)) begin
                     item.left_outer  = 1'b0;
                     item.right_outer = 1'b1;
                     if (item.left_inner && item.right_inner)
                        item.left_inner = 1'b0;
                  end else begin
                     item.left_outer  = 1'b1;
                     item.right_outer = 1'b0;
                  end
               end
               default: ;
            endcase
            if (kind != SCENE_WHITE)
               item.distance_step = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                                                  8'($urandom_range(0, 60));
            send_item(item, 1'b0, '0);
            sent++;
         end
      end
   endtask

   task automatic run_phase(cfg_type c, int phase, bit edge_cases);
      send_idle_pct = SendIdlePct[phase % 4];
      rsp_stall_pct = StallPct[phase % 4];
      write_csr(CSR_SPEED_CURVE, 14'(c.speed_curve));
      write_csr(CSR_SPEED_STOP, 14'(c.speed_stop));
      write_csr(CSR_SPEED_FAST, 14'(c.speed_fast));
      write_csr(CSR_RING_ENABLE, 14'(c.ring_enable));
      write_csr(CSR_DRIVE_DUTY, c.drive_duty);
      if (edge_cases) begin
         // Values wider than the register keep only the low bits.
         write_csr(CSR_SPEED_CURVE, '1);
         write_csr(CSR_SPEED_STOP, 14'h3F00);
         write_csr(CSR_RING_ENABLE, 14'h3FFE);
         write_csr(CSR_DRIVE_DUTY, '1);
         for (int i = CSR_PAST_END; i < (1 << CsrIndexWidth); i++)
            write_csr(CsrIndexWidth'(i), 14'h1555);
      end
      csr_we <= 1'b0;
      if (edge_cases) begin
         // A long all-white run at full step lets the counter pin at its maximum.
         repeat (CruiseItems)
            send_item(req_type'({5'b11111, 8'd255}), 1'b0, '0);
      end
      drive_track(PhaseItems);
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("transaction on the result side with nothing expected");
            end else begin
               want_rsp = expected_q.pop_front();
               compare_field("speed_out", rsp_data.speed_out, want_rsp.speed_out);
               compare_field("steer_enable", 8'(rsp_data.steer_enable),
                             8'(want_rsp.steer_enable));
               compare_field("steer_offset", rsp_data.steer_offset, want_rsp.steer_offset);
               compare_field("speed_loop_on", 8'(rsp_data.speed_loop_on),
                             8'(want_rsp.speed_loop_on));
               compare_field("drive_load", 8'(rsp_data.drive_load), 8'(want_rsp.drive_load));
               compare_field("mode_out", 8'(rsp_data.mode_out), 8'(want_rsp.mode_out));
               compare_field("ring_out", 8'(rsp_data.ring_out), 8'(want_rsp.ring_out));
               compare_field("lost_out", 8'(rsp_data.lost_out), 8'(want_rsp.lost_out));
               compare_field("cross_out", 8'(rsp_data.cross_out), 8'(want_rsp.cross_out));
               compare_field("stop_out", 8'(rsp_data.stop_out), 8'(want_rsp.stop_out));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   initial begin
      cfg_type c;
      reg_shadow = '{speed_curve: SPEED_CURVE_RESET, speed_stop: SPEED_STOP_RESET,
                     speed_fast: SPEED_FAST_RESET, ring_enable: 1'b0,
                     drive_duty: DRIVE_DUTY_RESET};
      trip_dist  = '0;
      elem_mode  = MODE_NORMAL;
      ring_ph    = RING_IDLE;
      lost_ph    = LOST_IDLE;
      cross_ph   = CROSS_IDLE;
      stop_seen  = 1'b0;
      speed_val  = '0;
      steer_on   = 1'b0;
      pwm_on     = 1'b0;
      offset_val = OFS_ZERO;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(req_type'({dir_rows[i].eyes, dir_rows[i].step}), dir_rows[i].typed,
                   dir_rows[i].want);
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);

      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: c = '{speed_curve: 8'd0, speed_stop: 8'd255, speed_fast: 8'd255,
                     ring_enable: 1'b1, drive_duty: 14'd0};
            1: c = '{speed_curve: 8'd255, speed_stop: 8'd0, speed_fast: 8'd0,
                     ring_enable: 1'b0, drive_duty: 14'd10000};
            default: c = '{speed_curve: 8'($urandom_range(0, 255)),
                           speed_stop: 8'($urandom_range(0, 255)),
                           speed_fast: 8'($urandom_range(0, 255)),
                           ring_enable: 1'($urandom_range(0, 1)),
                           drive_duty: 14'($urandom_range(0, 10000))};
         endcase
         run_phase(c, p, p == 1);
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
